### design/mutex_condvar_wait_queue_unit_assert.svh
// Assertion macros for the mutex / condition-variable wait unit.
// Depends on clk and arst_n being visible in the including module.
`ifndef MUTEX_CONDVAR_WAIT_QUEUE_UNIT_ASSERT_SVH
`define MUTEX_CONDVAR_WAIT_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define MCWQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MCWQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/mcwq_pkg.sv
// Package for the mutex / condition-variable wait unit.
// Beat types, command and status codes, state encoding, default sizes.
package mcwq_pkg;

	localparam int DEF_NUM_MUTEXES    = 16;
	localparam int DEF_NUM_CONDS      = 16;
	localparam int DEF_POOL_NODES     = 256;
	localparam int DEF_THREAD_ID_BITS = 8;
	localparam int DEF_COUNT_BITS     = 16;

	typedef enum logic [2:0] {
		CMD_INIT      = 3'd0,
		CMD_TRYLOCK   = 3'd1,
		CMD_UNLOCK    = 3'd2,
		CMD_WAIT      = 3'd3,
		CMD_POLL      = 3'd4,
		CMD_SIGNAL    = 3'd5,
		CMD_BROADCAST = 3'd6,
		CMD_DESTROY   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BUSY      = 3'd1,
		ST_INVALID   = 3'd2,
		ST_NOT_OWNER = 3'd3,
		ST_POOL_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] requester;
		logic [3:0] mutex_index;
		logic [3:0] cond_index;
		logic       make_recursive;
	} in_beat_t;

	typedef struct packed {
		logic [2:0] status;
		logic       still_waiting;
		logic       queue_empty;
	} out_beat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_DISPATCH,
		S_WALK_RD,
		S_WALK_CMP,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_LINK_WR,
		S_UNLOCK,
		S_POP_RD,
		S_POP_WR,
		S_FIN
	} fsm_t;

endpackage

### design/mutex_condvar_wait_queue_unit.sv
// Top level of the mutex / condition-variable wait unit.
// Depends on mcwq_pkg and mutex_condvar_wait_queue_unit_assert.svh.
//
// One command is handled at a time. Init, trylock and destroy are resolved at
// dispatch, unlock in its own unlock state. Cond wait and poll walk the
// addressed queue through the node pool memory, one link read and one thread
// compare per node passed. A wait then releases the mutex, after appending a
// node from the free chain if the thread was not found; an empty pool ends it.
// Signal removes the head node and broadcast removes every node in turn; each
// removal is one read and one write of the link memory. The unit is ready for
// the next command in the same cycle that out_valid rises. While an earlier
// result is still not taken, the next command holds in its final state. No
// clearing pass is needed after reset: a fill count stands in for the
// untouched free chain.
`include "mutex_condvar_wait_queue_unit_assert.svh"

module mutex_condvar_wait_queue_unit #(
	parameter int NUM_MUTEXES    = mcwq_pkg::DEF_NUM_MUTEXES,
	parameter int NUM_CONDS      = mcwq_pkg::DEF_NUM_CONDS,
	parameter int POOL_NODES     = mcwq_pkg::DEF_POOL_NODES,
	parameter int THREAD_ID_BITS = mcwq_pkg::DEF_THREAD_ID_BITS,
	parameter int COUNT_BITS     = mcwq_pkg::DEF_COUNT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mcwq_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mcwq_pkg::out_beat_t out_data
);
	import mcwq_pkg::*;

	localparam int NB = $clog2(POOL_NODES + 1);
	localparam int AB = $clog2(POOL_NODES);
	localparam int MB = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
	localparam int CB = (NUM_CONDS > 1) ? $clog2(NUM_CONDS) : 1;
	localparam int TB = THREAD_ID_BITS;
	localparam int KB = COUNT_BITS;
	localparam int MW = 1 + KB + TB;
	localparam int QW = 2 * NB;
	localparam logic [NB-1:0] NULL_N = NB'(POOL_NODES);

	// memories
	logic [MW-1:0] mut_mem [NUM_MUTEXES];
	logic [QW-1:0] cond_mem [NUM_CONDS];
	logic [TB-1:0] thr_mem [POOL_NODES];
	logic [NB-1:0] lnk_mem [POOL_NODES];

	logic [NUM_MUTEXES-1:0] mut_vld_q;
	logic [NUM_CONDS-1:0]   cond_vld_q;

	logic          mut_re, mut_we, cond_re, cond_we, lnk_re, lnk_we, thr_we;
	logic [MW-1:0] mut_wd, mut_rd;
	logic [QW-1:0] cond_wd, cond_rd;
	logic [AB-1:0] lnk_ra, lnk_wa;
	logic [NB-1:0] lnk_wd, lnk_rd;
	logic [TB-1:0] thr_rd;

	fsm_t state_q, state_d;

	cmd_t          cmd_q;
	logic [TB-1:0] tid_q;
	logic [MB-1:0] mi_q;
	logic [CB-1:0] ci_q;
	logic          rec_q, c_ok_q, bad_q;
	logic [MW-1:0] mut_q;
	logic [NB-1:0] head_q, tail_q, cur_q, free_q, hw_q;
	status_t       status_q;
	logic          wait_q;
	out_beat_t     out_q;
	logic          out_valid_q;

	logic          acc;
	logic [MB-1:0] in_mi;
	logic [CB-1:0] in_ci;
	logic          in_m_ok, in_c_ok, in_bad;
	logic [TB-1:0] in_tid;
	cmd_t          in_cmd;

	logic [TB-1:0] own;
	logic [KB-1:0] cnt;
	logic          rec;
	status_t       lk_st, ul_st;
	logic [MW-1:0] lk_new, ul_new;
	logic [NB-1:0] lnk_addr, lnk_eff;
	logic          hit;

	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign in_cmd  = cmd_t'(in_data.command);
	assign in_tid  = TB'(in_data.requester);
	assign in_mi   = MB'(in_data.mutex_index);
	assign in_ci   = CB'(in_data.cond_index);
	assign in_m_ok = 32'(in_data.mutex_index) < NUM_MUTEXES;
	assign in_c_ok = 32'(in_data.cond_index) < NUM_CONDS;
	assign in_bad  = ((in_cmd inside {[CMD_INIT:CMD_WAIT]}) && !in_m_ok) ||
		((in_cmd inside {[CMD_WAIT:CMD_DESTROY]}) && !in_c_ok) ||
		((in_cmd inside {[CMD_TRYLOCK:CMD_POLL]}) && (in_tid == '0));

	// lock arithmetic on the fetched mutex entry
	assign own = mut_q[TB-1:0];
	assign cnt = mut_q[TB+KB-1:TB];
	assign rec = mut_q[MW-1];

	always_comb begin
		lk_new = mut_q;
		lk_st  = ST_BUSY;
		if (rec && (own == tid_q)) begin
			if (cnt != '1) begin
				lk_new = {rec, cnt + KB'(1), own};
				lk_st  = ST_OK;
			end
		end else if (own == '0) begin
			lk_new = {rec, KB'(1), tid_q};
			lk_st  = ST_OK;
		end
	end

	always_comb begin
		ul_new = mut_q;
		if (own == '0) begin
			ul_st = ST_INVALID;
		end else if (own != tid_q) begin
			ul_st = ST_NOT_OWNER;
		end else begin
			ul_st = ST_OK;
			if (cnt <= KB'(1)) begin
				ul_new = {rec, KB'(0), TB'(0)};
			end else begin
				ul_new = {rec, cnt - KB'(1), own};
			end
		end
	end

	// nodes at or above the fill mark have never been written and link to the next node
	always_comb begin
		case (state_q)
			S_WALK_CMP: lnk_addr = cur_q;
			S_ALLOC_WR: lnk_addr = free_q;
			default:    lnk_addr = head_q;
		endcase
		lnk_eff = (lnk_addr >= hw_q) ? lnk_addr + NB'(1) : lnk_rd;
	end

	assign hit = (thr_rd == tid_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) state_d = S_READ;
			end
			S_READ: state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (bad_q) begin
					state_d = S_FIN;
				end else begin
					case (cmd_q)
						CMD_UNLOCK:                state_d = S_UNLOCK;
						CMD_WAIT, CMD_POLL:        state_d = S_WALK_RD;
						CMD_SIGNAL, CMD_BROADCAST:
							state_d = (head_q == NULL_N) ? S_FIN : S_POP_RD;
						default:                   state_d = S_FIN;
					endcase
				end
			end
			S_WALK_RD: begin
				if (cur_q != NULL_N)         state_d = S_WALK_CMP;
				else if (cmd_q == CMD_POLL)  state_d = S_FIN;
				else                         state_d = S_ALLOC_RD;
			end
			S_WALK_CMP: begin
				if (!hit)                    state_d = S_WALK_RD;
				else if (cmd_q == CMD_POLL)  state_d = S_FIN;
				else                         state_d = S_UNLOCK;
			end
			S_ALLOC_RD: state_d = (free_q == NULL_N) ? S_FIN : S_ALLOC_WR;
			S_ALLOC_WR: state_d = (head_q == NULL_N) ? S_UNLOCK : S_LINK_WR;
			S_LINK_WR:  state_d = S_UNLOCK;
			S_UNLOCK:   state_d = S_FIN;
			S_POP_RD:   state_d = S_POP_WR;
			S_POP_WR: begin
				if ((cmd_q == CMD_BROADCAST) && (lnk_eff != NULL_N)) state_d = S_POP_RD;
				else                                                   state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		mut_re  = 1'b0;
		mut_we  = 1'b0;
		mut_wd  = mut_q;
		cond_re = 1'b0;
		cond_we = 1'b0;
		cond_wd = {head_q, tail_q};
		lnk_re  = 1'b0;
		lnk_ra  = AB'(cur_q);
		lnk_we  = 1'b0;
		lnk_wa  = AB'(free_q);
		lnk_wd  = NULL_N;
		thr_we  = 1'b0;
		case (state_q)
			S_IDLE: begin
				mut_re  = acc;
				cond_re = acc;
			end
			S_DISPATCH: begin
				if (!bad_q && (cmd_q == CMD_INIT)) begin
					mut_we = 1'b1;
					mut_wd = {rec_q, KB'(0), TB'(0)};
				end else if (!bad_q && (cmd_q == CMD_TRYLOCK)) begin
					mut_we = (lk_st == ST_OK);
					mut_wd = lk_new;
				end
			end
			S_WALK_RD: begin
				lnk_re = (cur_q != NULL_N);
				lnk_ra = AB'(cur_q);
			end
			S_ALLOC_RD: begin
				lnk_re = (free_q != NULL_N);
				lnk_ra = AB'(free_q);
			end
			S_ALLOC_WR: begin
				thr_we = 1'b1;
				lnk_we = 1'b1;
				lnk_wa = AB'(free_q);
				lnk_wd = NULL_N;
				if (head_q == NULL_N) begin
					cond_we = 1'b1;
					cond_wd = {free_q, free_q};
				end
			end
			S_LINK_WR: begin
				lnk_we  = 1'b1;
				lnk_wa  = AB'(tail_q);
				lnk_wd  = cur_q;
				cond_we = 1'b1;
				cond_wd = {head_q, cur_q};
			end
			S_UNLOCK: begin
				mut_we = (ul_st == ST_OK);
				mut_wd = ul_new;
			end
			S_POP_RD: begin
				lnk_re = 1'b1;
				lnk_ra = AB'(head_q);
			end
			S_POP_WR: begin
				lnk_we  = 1'b1;
				lnk_wa  = AB'(head_q);
				lnk_wd  = free_q;
				cond_we = 1'b1;
				cond_wd = (lnk_eff == NULL_N) ? {NULL_N, NULL_N} : {lnk_eff, tail_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mut_we) mut_mem[mi_q] <= mut_wd;
		if (mut_re) mut_rd <= mut_mem[in_mi];
	end

	always_ff @(posedge clk) begin
		if (cond_we) cond_mem[ci_q] <= cond_wd;
		if (cond_re) cond_rd <= cond_mem[in_ci];
	end

	always_ff @(posedge clk) begin
		if (thr_we) thr_mem[AB'(free_q)] <= tid_q;
		if (lnk_re) thr_rd <= thr_mem[lnk_ra];
	end

	always_ff @(posedge clk) begin
		if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
		if (lnk_re) lnk_rd <= lnk_mem[lnk_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mut_vld_q   <= '0;
			cond_vld_q  <= '0;
			free_q      <= '0;
			hw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mut_we)  mut_vld_q[mi_q]  <= 1'b1;
			if (cond_we) cond_vld_q[ci_q] <= 1'b1;
			if (state_q == S_ALLOC_WR) begin
				free_q <= lnk_eff;
				if (free_q >= hw_q) hw_q <= free_q + NB'(1);
			end
			if (state_q == S_POP_WR) free_q <= head_q;
			if ((state_q == S_FIN) && (state_d == S_IDLE)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q    <= in_cmd;
				tid_q    <= in_tid;
				mi_q     <= in_mi;
				ci_q     <= in_ci;
				rec_q    <= in_data.make_recursive;
				c_ok_q   <= in_c_ok;
				bad_q    <= in_bad;
				status_q <= ST_OK;
				wait_q   <= 1'b0;
			end
			S_READ: begin
				mut_q  <= mut_vld_q[mi_q] ? mut_rd : '0;
				head_q <= cond_vld_q[ci_q] ? cond_rd[QW-1:NB] : NULL_N;
				tail_q <= cond_vld_q[ci_q] ? cond_rd[NB-1:0] : NULL_N;
			end
			S_DISPATCH: begin
				cur_q <= head_q;
				if (bad_q) begin
					status_q <= ST_INVALID;
				end else begin
					case (cmd_q)
						CMD_TRYLOCK: status_q <= lk_st;
						CMD_DESTROY: status_q <= (head_q == NULL_N) ? ST_OK : ST_BUSY;
						default:     status_q <= ST_OK;
					endcase
				end
			end
			S_WALK_CMP: begin
				cur_q <= lnk_eff;
				if (hit) wait_q <= (cmd_q == CMD_POLL);
			end
			S_ALLOC_RD: begin
				if (free_q == NULL_N) status_q <= ST_POOL_FULL;
			end
			S_ALLOC_WR: begin
				cur_q <= free_q;
				if (head_q == NULL_N) begin
					head_q <= free_q;
					tail_q <= free_q;
				end
			end
			S_LINK_WR: tail_q <= cur_q;
			S_UNLOCK:  status_q <= ul_st;
			S_POP_WR: begin
				if (lnk_eff == NULL_N) begin
					head_q <= NULL_N;
					tail_q <= NULL_N;
				end else begin
					head_q <= lnk_eff;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_q.status        <= status_q;
					out_q.still_waiting <= wait_q;
					out_q.queue_empty   <= !c_ok_q || (head_q == NULL_N);
				end
			end
			default: begin
			end
		endcase
	end

	`MCWQ_ASSERT_NOW(a_fill_bound, 1'b1, hw_q <= NULL_N, "fill mark beyond pool")
	`MCWQ_ASSERT_NOW(a_empty_pool, free_q == NULL_N, hw_q == NULL_N,
		"free list empty before pool filled")
	`MCWQ_ASSERT_NXT(a_accept_read, acc, state_q == S_READ, "accept did not start read")
	`MCWQ_ASSERT_NOW(a_result_src, $rose(out_valid_q), $past(state_q) == S_FIN,
		"result raised outside final state")

endmodule

### tb/mutex_condvar_wait_queue_unit_test.sv
// Self-checking testbench for mutex_condvar_wait_queue_unit: mutex and
// condition-queue commands in, one status beat out, checked against a behavioral copy.
// Depends on mcwq_pkg and the unit's RTL.
`timescale 1ns / 1ps

module mutex_condvar_wait_queue_unit_test;
	import mcwq_pkg::*;

	localparam int NM = DEF_NUM_MUTEXES;
	localparam int NC = DEF_NUM_CONDS;
	localparam int NP = DEF_POOL_NODES;
	localparam int CMAX = (1 << DEF_COUNT_BITS) - 1;
	localparam int IBW = $bits(in_beat_t);

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_beat_t out_data;

	mutex_condvar_wait_queue_unit dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// behavioral state: locks and per-condition thread FIFOs plus pool use
	int owner[NM];
	int holds[NM];
	bit recur[NM];
	int cq[NC][$];
	int used_nodes;

	in_beat_t pending_cmds[$];
	out_beat_t expected_status[$];
	int errors = 0;
	int in_gap = 0, out_gap = 0;
	bit quiet = 0;

	function automatic bit thread_queued(int c, int t);
		for (int i = 0; i < cq[c].size(); i++) if (cq[c][i] == t) return 1;
		return 0;
	endfunction

	function automatic status_t release_lock(int m, int t);
		if (owner[m] == 0) return ST_INVALID;
		if (owner[m] != t) return ST_NOT_OWNER;
		if (holds[m] <= 1) begin
			holds[m] = 0;
			owner[m] = 0;
		end else holds[m]--;
		return ST_OK;
	endfunction

	function automatic out_beat_t apply_command(in_beat_t b);
		out_beat_t r;
		int m, c, t;
		cmd_t op;
		status_t st;
		m = b.mutex_index;
		c = b.cond_index;
		t = b.requester;
		op = cmd_t'(b.command);
		st = ST_OK;
		r = '0;
		if (op inside {CMD_TRYLOCK, CMD_UNLOCK, CMD_WAIT, CMD_POLL} && t == 0)
			st = ST_INVALID;
		else case (op)
			CMD_INIT: begin
				owner[m] = 0;
				holds[m] = 0;
				recur[m] = b.make_recursive;
			end
			CMD_TRYLOCK: begin
				if (recur[m] && owner[m] == t) begin
					if (holds[m] >= CMAX) st = ST_BUSY;
					else holds[m]++;
				end else if (owner[m] == 0) begin
					owner[m] = t;
					holds[m] = 1;
				end else st = ST_BUSY;
			end
			CMD_UNLOCK: st = release_lock(m, t);
			CMD_WAIT: begin
				if (!thread_queued(c, t) && used_nodes >= NP) st = ST_POOL_FULL;
				else begin
					if (!thread_queued(c, t)) begin
						cq[c].push_back(t);
						used_nodes++;
					end
					st = release_lock(m, t);
				end
			end
			CMD_POLL: r.still_waiting = thread_queued(c, t);
			CMD_SIGNAL: if (cq[c].size() > 0) begin
				void'(cq[c].pop_front());
				used_nodes--;
			end
			CMD_BROADCAST: begin
				used_nodes -= cq[c].size();
				cq[c].delete();
			end
			default: st = (cq[c].size() > 0) ? ST_BUSY : ST_OK;
		endcase
		r.status = st;
		r.queue_empty = (cq[c].size() == 0);
		return r;
	endfunction

	function automatic in_beat_t mk(cmd_t op, int t, int m, int c, bit rc);
		in_beat_t b;
		b.command = op;
		b.requester = 8'(t);
		b.mutex_index = 4'(m);
		b.cond_index = 4'(c);
		b.make_recursive = rc;
		return b;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_status.push_back(apply_command(in_data));
			if (!(in_valid && !in_ready)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 0;
				end else if (pending_cmds.size() > 0) begin
					in_data <= pending_cmds.pop_front();
					in_valid <= 1;
					if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 8);
				end else in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					$display("%0t: unexpected beat %p", $time, out_data);
					errors++;
				end else begin
					e = expected_status.pop_front();
					if (out_data.status !== e.status)
						$display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
					if (out_data.still_waiting !== e.still_waiting)
						$display("%0t: still_waiting exp %0d got %0d", $time,
							e.still_waiting, out_data.still_waiting);
					if (out_data.queue_empty !== e.queue_empty)
						$display("%0t: queue_empty exp %0d got %0d", $time,
							e.queue_empty, out_data.queue_empty);
					if (out_data !== e) errors++;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (!quiet && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 8);
			end
		end
	end

	task automatic add_random(int n);
		int t, m, c, k;
		for (int i = 0; i < n; i++) begin
			t = $urandom_range(1, 6);
			m = $urandom_range(0, 3);
			c = $urandom_range(0, 3);
			k = $urandom_range(0, 19);
			if (k == 0) pending_cmds.push_back(in_beat_t'(IBW'($urandom)));
			else if (k < 4) begin
				// lock, wait, poll, then signal, broadcast or destroy: the usual sequence
				pending_cmds.push_back(mk(CMD_TRYLOCK, t, m, c, 0));
				pending_cmds.push_back(mk(CMD_WAIT, t, m, c, 0));
				pending_cmds.push_back(mk(CMD_POLL, t, m, c, 0));
				pending_cmds.push_back(mk(cmd_t'($urandom_range(5, 7)), t, m, c, 0));
				i += 3;
			end else
				pending_cmds.push_back(mk(cmd_t'($urandom_range(0, 7)),
					($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : t,
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : m,
					($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : c,
					$urandom_range(0, 1)));
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_status.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		foreach (owner[i]) begin
			owner[i] = 0;
			holds[i] = 0;
			recur[i] = 0;
		end
		used_nodes = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		pending_cmds.push_back(mk(CMD_UNLOCK, 1, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_TRYLOCK, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_INIT, 0, 15, 15, 1));
		pending_cmds.push_back(mk(CMD_TRYLOCK, 255, 15, 15, 0));
		pending_cmds.push_back(mk(CMD_TRYLOCK, 255, 15, 15, 0));
		pending_cmds.push_back(mk(CMD_TRYLOCK, 7, 15, 15, 0));
		pending_cmds.push_back(mk(CMD_UNLOCK, 7, 15, 15, 0));
		pending_cmds.push_back(mk(CMD_TRYLOCK, 3, 1, 0, 0));
		pending_cmds.push_back(mk(CMD_TRYLOCK, 3, 1, 0, 0));
		pending_cmds.push_back(mk(CMD_WAIT, 3, 1, 2, 0));
		pending_cmds.push_back(mk(CMD_WAIT, 3, 1, 2, 0));
		pending_cmds.push_back(mk(CMD_POLL, 3, 0, 2, 0));
		pending_cmds.push_back(mk(CMD_POLL, 4, 0, 2, 0));
		pending_cmds.push_back(mk(CMD_DESTROY, 0, 0, 2, 0));
		pending_cmds.push_back(mk(CMD_SIGNAL, 0, 0, 2, 0));
		pending_cmds.push_back(mk(CMD_SIGNAL, 0, 0, 2, 0));
		pending_cmds.push_back(mk(CMD_BROADCAST, 0, 0, 5, 0));
		pending_cmds.push_back(mk(CMD_INIT, 0, 15, 0, 0));
		pending_cmds.push_back(mk(CMD_DESTROY, 0, 0, 2, 0));
		wait_drained();
		// fill the pool past its end, then drain it
		for (int i = 0; i < NP + 2; i++)
			pending_cmds.push_back(mk(CMD_WAIT, 1 + (i % 255), 0, 8 + i / 255, 0));
		for (int c = 8; c < 10; c++) begin
			pending_cmds.push_back(mk(CMD_DESTROY, 0, 0, c, 0));
			pending_cmds.push_back(mk(CMD_BROADCAST, 0, 0, c, 0));
		end
		wait_drained();
		add_random(400);
		wait_drained();
		quiet = 1;
		add_random(120);
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

### mutex_condvar_wait_queue_unit.f
+incdir+design
design/mcwq_pkg.sv
design/mutex_condvar_wait_queue_unit.sv
tb/mutex_condvar_wait_queue_unit_test.sv
